// ----- rtl/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, register indexes and defaults of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int BLOCK_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int NUM_BLOCKS_DEFAULT  = 4;
   localparam int MAX_REGIONS_DEFAULT = 16;
   localparam int ADDR_WIDTH_DEFAULT  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIT_MODE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_SIZE_0 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_SIZE_3 = 3'd4;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                  found;
      logic                  after;
      logic [DATA_WIDTH-1:0] len;
   } cand_type;

   typedef struct packed {
      logic                  take;
      logic                  after;
      logic [DATA_WIDTH-1:0] len;
   } gap_result_type;

endpackage

// ----- rtl/cfa_region_mem.sv -----
// ----------------------------------------------------------------------------
// cfa_region_mem
// Region table: start and length per entry, one write and one registered read.
// ----------------------------------------------------------------------------
module cfa_region_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int SW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [SW-1:0] wr_start,
   input  logic [SW-1:0] wr_length,
   input  logic [AW-1:0] rd_addr,
   output logic [SW-1:0] rd_start,
   output logic [SW-1:0] rd_length
);

   logic [SW-1:0] start_mem  [DEPTH];
   logic [SW-1:0] length_mem [DEPTH];
   logic [SW-1:0] rd_start_ff;
   logic [SW-1:0] rd_length_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr]  <= wr_start;
         length_mem[wr_addr] <= wr_length;
      end
      rd_start_ff  <= start_mem[rd_addr];
      rd_length_ff <= length_mem[rd_addr];
   end

   assign rd_start  = rd_start_ff;
   assign rd_length = rd_length_ff;

endmodule

// ----- rtl/cfa_gap_eval.sv -----
// ----------------------------------------------------------------------------
// cfa_gap_eval
// Gap unit: measures one free gap and decides whether it replaces the
// current candidate under the selected fit policy.
// ----------------------------------------------------------------------------
module cfa_gap_eval (
   input  logic [cfa_pkg::DATA_WIDTH-1:0]  gap_lo,
   input  logic [cfa_pkg::DATA_WIDTH-1:0]  gap_hi,
   input  logic [cfa_pkg::DATA_WIDTH-1:0]  req_size,
   input  cfa_pkg::fit_mode_type           mode,
   input  logic [cfa_pkg::BLOCK_WIDTH-1:0] blk,
   input  logic [cfa_pkg::BLOCK_WIDTH-1:0] cursor_block,
   input  logic [cfa_pkg::DATA_WIDTH-1:0]  cursor_offset,
   input  cfa_pkg::cand_type               cand,
   output cfa_pkg::gap_result_type         result
);
   import cfa_pkg::*;

   logic [DATA_WIDTH-1:0] len;
   logic                  fits;
   logic                  after;
   logic                  take;

   always_comb begin
      len   = gap_hi - gap_lo;
      fits  = (gap_hi > gap_lo) && (len >= req_size);
      after = (blk > cursor_block) || ((blk == cursor_block) && (gap_lo >= cursor_offset));
      case (mode)
         FIT_FIRST: take = fits && !cand.found;
         FIT_BEST:  take = fits && (!cand.found || (len < cand.len));
         FIT_WORST: take = fits && (!cand.found || (len > cand.len));
         FIT_NEXT:  take = fits && (!cand.found || (after && !cand.after));
         default:   take = 1'b0;
      endcase
      result.take  = take;
      result.after = after;
      result.len   = len;
   end

endmodule

// ----- rtl/contiguous_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Places each request in a free gap of one of NUM_BLOCKS memory blocks and
// returns grant, block and offset. A request visits every gap of every block
// in order; for each gap it reads the region table, then passes the gap
// through the gap unit. It then moves the regions above the chosen gap up by
// one, reading and writing back each moved entry, and writes the new region.
// A refused request skips the move and the write, and a request of size zero
// is refused without a scan. A new request is taken only in idle, once the
// last one is finished. Results wait in an output register, so the next
// request is taken while the last result is still stalled.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
   parameter int NUM_BLOCKS  = cfa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int MAX_REGIONS = cfa_pkg::MAX_REGIONS_DEFAULT,
   parameter int ADDR_WIDTH  = cfa_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cfa_pkg::DATA_WIDTH-1:0]      req_request_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_granted,
   output logic [cfa_pkg::BLOCK_WIDTH-1:0]     rsp_chosen_block,
   output logic [cfa_pkg::DATA_WIDTH-1:0]      rsp_start_offset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cfa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfa_pkg::DATA_WIDTH-1:0]      csr_wdata
);
   import cfa_pkg::*;

   localparam int IW        = $clog2(MAX_REGIONS);
   localparam int CW        = $clog2(MAX_REGIONS + 1);
   localparam int BW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int MEM_DEPTH = NUM_BLOCKS * (2 ** IW);
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int SW        = (ADDR_WIDTH < DATA_WIDTH) ? ADDR_WIDTH : DATA_WIDTH;
   localparam logic [DATA_WIDTH-1:0] CAP_MAX = (ADDR_WIDTH >= DATA_WIDTH) ?
      {DATA_WIDTH{1'b1}} : DATA_WIDTH'((64'd1 << ADDR_WIDTH) - 64'd1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_REGIONS);
   localparam logic [BW-1:0] LAST_BLK  = BW'(NUM_BLOCKS - 1);

   state_type               state_ff, state_in;
   fit_mode_type            fit_mode_ff, fit_mode_in;
   logic [DATA_WIDTH-1:0]   block_size_ff [NUM_BLOCKS];
   logic [DATA_WIDTH-1:0]   block_size_in [NUM_BLOCKS];
   logic [CW-1:0]           count_ff [NUM_BLOCKS];
   logic [CW-1:0]           count_in [NUM_BLOCKS];
   logic [BLOCK_WIDTH-1:0]  cursor_block_ff, cursor_block_in;
   logic [SW-1:0]           cursor_offset_ff, cursor_offset_in;
   logic [DATA_WIDTH-1:0]   req_size_ff, req_size_in;
   logic [BW-1:0]           blk_ff, blk_in;
   logic [CW-1:0]           gap_ff, gap_in;
   logic [DATA_WIDTH-1:0]   prev_end_ff, prev_end_in;
   cand_type                cand_ff, cand_in;
   logic [BW-1:0]           fb_ff, fb_in;
   logic [CW-1:0]           fg_ff, fg_in;
   logic [DATA_WIDTH-1:0]   fs_ff, fs_in;
   logic                    res_granted_ff, res_granted_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [BLOCK_WIDTH-1:0]  rsp_block_ff, rsp_block_in;
   logic [DATA_WIDTH-1:0]   rsp_offset_ff, rsp_offset_in;

   logic                    scanning;
   logic [BW-1:0]           cnt_idx;
   logic [CW-1:0]           cnt_sel;
   logic [DATA_WIDTH-1:0]   cap_raw;
   logic [DATA_WIDTH-1:0]   cap_sel;
   logic                    at_tail;
   logic                    last_blk;
   logic                    out_free;
   logic                    req_take;
   logic [CW-1:0]           gap_dec;
   logic [DATA_WIDTH-1:0]   gap_hi;
   logic                    mem_we;
   logic [MEM_AW-1:0]       mem_waddr;
   logic [SW-1:0]           mem_wstart;
   logic [SW-1:0]           mem_wlength;
   logic [MEM_AW-1:0]       mem_raddr;
   logic [SW-1:0]           mem_rstart;
   logic [SW-1:0]           mem_rlength;
   gap_result_type          gap_res;

   cfa_region_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (MEM_AW),
      .SW    (SW)
   ) u_region_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_start  (mem_wstart),
      .wr_length (mem_wlength),
      .rd_addr   (mem_raddr),
      .rd_start  (mem_rstart),
      .rd_length (mem_rlength)
   );

   cfa_gap_eval u_gap_eval (
      .gap_lo        (prev_end_ff),
      .gap_hi        (gap_hi),
      .req_size      (req_size_ff),
      .mode          (fit_mode_ff),
      .blk           (BLOCK_WIDTH'(blk_ff)),
      .cursor_block  (cursor_block_ff),
      .cursor_offset (DATA_WIDTH'(cursor_offset_ff)),
      .cand          (cand_ff),
      .result        (gap_res)
   );

   assign scanning  = (state_ff == ST_SCAN_RD) || (state_ff == ST_SCAN_EV);
   assign cnt_idx   = scanning ? blk_ff : fb_ff;
   assign cnt_sel   = count_ff[cnt_idx];
   assign cap_raw   = block_size_ff[blk_ff];
   assign cap_sel   = (cap_raw > CAP_MAX) ? CAP_MAX : cap_raw;
   assign at_tail   = (gap_ff == cnt_sel);
   assign last_blk  = (blk_ff == LAST_BLK);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign gap_dec   = gap_ff - 1'b1;
   assign gap_hi    = at_tail ? cap_sel : DATA_WIDTH'(mem_rstart);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_request_size == '0) ? ST_FINISH : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: state_in = (at_tail && last_blk) ? ST_DECIDE : ST_SCAN_RD;
         ST_DECIDE: begin
            if (!cand_ff.found || (cnt_sel >= MAX_COUNT)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: state_in = (gap_ff > fg_ff) ? ST_SHIFT_WR : ST_INSERT;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_INSERT:   state_in = ST_FINISH;
         ST_FINISH:   state_in = out_free ? ST_IDLE : ST_FINISH;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      csr_ready        = 1'b1;
      fit_mode_in      = fit_mode_ff;
      block_size_in    = block_size_ff;
      count_in         = count_ff;
      cursor_block_in  = cursor_block_ff;
      cursor_offset_in = cursor_offset_ff;
      req_size_in      = req_size_ff;
      blk_in           = blk_ff;
      gap_in           = gap_ff;
      prev_end_in      = prev_end_ff;
      cand_in          = cand_ff;
      fb_in            = fb_ff;
      fg_in            = fg_ff;
      fs_in            = fs_ff;
      res_granted_in   = res_granted_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_granted_in   = rsp_granted_ff;
      rsp_block_in     = rsp_block_ff;
      rsp_offset_in    = rsp_offset_ff;
      mem_we           = 1'b0;
      mem_waddr        = MEM_AW'({fb_ff, gap_ff[IW-1:0]});
      mem_wstart       = mem_rstart;
      mem_wlength      = mem_rlength;
      mem_raddr        = MEM_AW'({blk_ff, gap_ff[IW-1:0]});

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIT_MODE) begin
            fit_mode_in = fit_mode_type'(csr_wdata[1:0]);
         end else if ((csr_index >= CSR_BLOCK_SIZE_0) && (csr_index <= CSR_BLOCK_SIZE_3)) begin
            for (int k = 0; k < NUM_BLOCKS; k++) begin
               if (csr_index == CSR_BLOCK_SIZE_0 + CSR_INDEX_WIDTH'(k)) begin
                  block_size_in[k] = csr_wdata;
               end
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_size_in    = req_request_size;
               blk_in         = '0;
               gap_in         = '0;
               prev_end_in    = '0;
               cand_in        = '0;
               res_granted_in = 1'b0;
            end
         end
         ST_SCAN_EV: begin
            if (gap_res.take) begin
               cand_in.found = 1'b1;
               cand_in.after = gap_res.after;
               cand_in.len   = gap_res.len;
               fb_in         = blk_ff;
               fg_in         = gap_ff;
               fs_in         = prev_end_ff;
            end
            if (at_tail) begin
               if (!last_blk) begin
                  blk_in = blk_ff + 1'b1;
               end
               gap_in      = '0;
               prev_end_in = '0;
            end else begin
               gap_in      = gap_ff + 1'b1;
               prev_end_in = DATA_WIDTH'(mem_rstart) + DATA_WIDTH'(mem_rlength);
            end
         end
         ST_DECIDE: begin
            gap_in = cnt_sel;
         end
         ST_SHIFT_RD: begin
            mem_raddr = MEM_AW'({fb_ff, gap_dec[IW-1:0]});
         end
         ST_SHIFT_WR: begin
            mem_we = 1'b1;
            gap_in = gap_dec;
         end
         ST_INSERT: begin
            mem_we           = 1'b1;
            mem_waddr        = MEM_AW'({fb_ff, fg_ff[IW-1:0]});
            mem_wstart       = fs_ff[SW-1:0];
            mem_wlength      = req_size_ff[SW-1:0];
            count_in[fb_ff]  = cnt_sel + 1'b1;
            cursor_block_in  = BLOCK_WIDTH'(fb_ff);
            cursor_offset_in = fs_ff[SW-1:0] + req_size_ff[SW-1:0];
            res_granted_in   = 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_block_in   = res_granted_ff ? BLOCK_WIDTH'(fb_ff) : '0;
               rsp_offset_in  = res_granted_ff ? fs_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         fit_mode_ff      <= FIT_FIRST;
         cursor_block_ff  <= '0;
         cursor_offset_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            block_size_ff[k] <= '0;
            count_ff[k]      <= '0;
         end
      end else begin
         state_ff         <= state_in;
         fit_mode_ff      <= fit_mode_in;
         cursor_block_ff  <= cursor_block_in;
         cursor_offset_ff <= cursor_offset_in;
         rsp_valid_ff     <= rsp_valid_in;
         block_size_ff    <= block_size_in;
         count_ff         <= count_in;
      end
      req_size_ff    <= req_size_in;
      blk_ff         <= blk_in;
      gap_ff         <= gap_in;
      prev_end_ff    <= prev_end_in;
      cand_ff        <= cand_in;
      fb_ff          <= fb_in;
      fg_ff          <= fg_in;
      fs_ff          <= fs_in;
      res_granted_ff <= res_granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_offset_ff  <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;
   assign rsp_start_offset = rsp_offset_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_SHIFT_WR) || (state_ff == ST_INSERT)))
      else $error("region table written outside shift or insert");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (cnt_sel < MAX_COUNT))
      else $error("insert into a full region table");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_WR) |-> (gap_ff > fg_ff))
      else $error("shift pointer below insertion point");

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> ((rsp_chosen_block == '0) && (rsp_start_offset == '0)))
      else $error("refused request carries a placement");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("request taken without leaving idle");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for contiguous_fit_allocator. A short scripted run covers
// empty blocks, zero and full-range sizes, all four fit modes, a refused wrap
// and a granted wrap in next fit, and block size changes over live regions.
// Randomised phases follow, each with its own fit mode, block sizes and idle
// profile. Responses are checked against scripted or placement model results.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfa_pkg::*;

   localparam int BLOCKS       = NUM_BLOCKS_DEFAULT;
   localparam int REGIONS      = MAX_REGIONS_DEFAULT;
   localparam int PHASES       = 14;
   localparam int PHASE_ITEMS  = 100;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int TAIL_CYCLES  = 200;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;
   localparam bit KNOWN   = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef struct packed {
      logic                   granted;
      logic [BLOCK_WIDTH-1:0] block;
      logic [DATA_WIDTH-1:0]  offset;
   } alloc_result_type;

   typedef enum logic {
      STEP_WRITE,
      STEP_REQUEST
   } step_kind_type;

   typedef struct packed {
      step_kind_type              kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [DATA_WIDTH-1:0]      value;
      bit                         known;
      alloc_result_type           want;
   } directed_step_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic [DATA_WIDTH-1:0]      req_request_size = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic                       rsp_granted;
   logic [BLOCK_WIDTH-1:0]     rsp_chosen_block;
   logic [DATA_WIDTH-1:0]      rsp_start_offset;
   logic                       csr_valid        = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [DATA_WIDTH-1:0]      csr_wdata        = '0;

   // placement model state
   fit_mode_type          mode_shadow = FIT_FIRST;
   logic [DATA_WIDTH-1:0] capacity [BLOCKS] = '{default: '0};
   logic [DATA_WIDTH-1:0] seg_base [BLOCKS][REGIONS];
   logic [DATA_WIDTH-1:0] seg_size [BLOCKS][REGIONS];
   int unsigned           seg_count [BLOCKS] = '{default: 0};
   logic [BLOCK_WIDTH-1:0] rover_block  = '0;
   logic [DATA_WIDTH-1:0]  rover_offset = '0;

   alloc_result_type  pending_grants [$];
   alloc_result_type  oldest_grant;
   directed_step_type script [32];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                gap_pct        = 0;
   int                stall_pct      = 0;
   int                stall_run      = 0;

   contiguous_fit_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_start_offset (rsp_start_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic directed_step_type poke(input logic [CSR_INDEX_WIDTH-1:0] index,
                                              input logic [DATA_WIDTH-1:0] value);
      directed_step_type s;
      s = '0;
      s.kind  = STEP_WRITE;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   function automatic directed_step_type ask(input logic [DATA_WIDTH-1:0] size,
                                             input bit known,
                                             input logic granted,
                                             input logic [BLOCK_WIDTH-1:0] block,
                                             input logic [DATA_WIDTH-1:0] offset);
      directed_step_type s;
      s = '0;
      s.kind         = STEP_REQUEST;
      s.value        = size;
      s.known        = known;
      s.want.granted = granted;
      s.want.block   = block;
      s.want.offset  = offset;
      return s;
   endfunction

   function automatic bit free_gap(input int b, input int g,
                                   output int unsigned lo, output int unsigned len);
      int unsigned n;
      int unsigned top;
      n = seg_count[b];
      if (g > n) return 1'b0;
      lo  = (g == 0) ? 0 : seg_base[b][g-1] + seg_size[b][g-1];
      top = (g == n) ? capacity[b] : seg_base[b][g];
      if (top <= lo) return 1'b0;
      len = top - lo;
      return 1'b1;
   endfunction

   function automatic alloc_result_type place_request(input logic [DATA_WIDTH-1:0] size);
      alloc_result_type r;
      bit               found;
      bit               after;
      bit               take_first;
      int               fb, fg, pass, b, g, i;
      int unsigned      fs, fl, lo, len;
      r          = '0;
      found      = 1'b0;
      fb         = 0;
      fg         = 0;
      fs         = 0;
      fl         = 0;
      take_first = (mode_shadow == FIT_FIRST) || (mode_shadow == FIT_NEXT);
      if (size == '0) return r;
      for (pass = 0; pass < 2 && !found; pass++) begin
         for (b = 0; b < BLOCKS; b++) begin
            if (found && take_first) break;
            for (g = 0; g <= seg_count[b]; g++) begin
               if (!free_gap(b, g, lo, len) || len < size) continue;
               if (mode_shadow == FIT_NEXT) begin
                  after = (b > rover_block) || (b == rover_block && lo >= rover_offset);
                  if (after != (pass == 0)) continue;
               end
               if (!found || (mode_shadow == FIT_BEST && len < fl) ||
                   (mode_shadow == FIT_WORST && len > fl)) begin
                  found = 1'b1;
                  fb    = b;
                  fg    = g;
                  fs    = lo;
                  fl    = len;
                  if (take_first) break;
               end
            end
         end
         if (mode_shadow != FIT_NEXT) break;
      end
      if (!found || seg_count[fb] >= REGIONS) return r;
      for (i = seg_count[fb]; i > fg; i--) begin
         seg_base[fb][i] = seg_base[fb][i-1];
         seg_size[fb][i] = seg_size[fb][i-1];
      end
      seg_base[fb][fg] = DATA_WIDTH'(fs);
      seg_size[fb][fg] = size;
      seg_count[fb]    = seg_count[fb] + 1;
      rover_block      = BLOCK_WIDTH'(fb);
      rover_offset     = DATA_WIDTH'(fs + size);
      r.granted        = 1'b1;
      r.block          = BLOCK_WIDTH'(fb);
      r.offset         = DATA_WIDTH'(fs);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_FIT_MODE) begin
         mode_shadow = fit_mode_type'(data[1:0]);
      end else if (index >= CSR_BLOCK_SIZE_0 && index <= CSR_BLOCK_SIZE_3) begin
         capacity[index - CSR_BLOCK_SIZE_0] = data;
      end
   endtask

   task automatic send_request(input logic [DATA_WIDTH-1:0] size, input bit known,
                               input alloc_result_type want);
      alloc_result_type predicted;
      int               gap;
      if (csr_valid) csr_valid <= 1'b0;
      req_valid        <= 1'b1;
      req_request_size <= size;
      do @(posedge clock); while (req_stall);
      predicted = place_request(size);
      pending_grants.insert(pending_grants.size(), known ? want : predicted);
      if ($urandom_range(0, 99) < gap_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end else begin
         gap = 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_grant = pending_grants.pop_front();
            if (rsp_granted !== oldest_grant.granted)
               report_mismatch($sformatf("granted %b, want %b",
                                         rsp_granted, oldest_grant.granted));
            if (rsp_chosen_block !== oldest_grant.block)
               report_mismatch($sformatf("chosen_block %0d, want %0d",
                                         rsp_chosen_block, oldest_grant.block));
            if (rsp_start_offset !== oldest_grant.offset)
               report_mismatch($sformatf("start_offset %0d, want %0d",
                                         rsp_start_offset, oldest_grant.offset));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int                    p, k, n;
      logic [DATA_WIDTH-1:0] size;
      logic [DATA_WIDTH-1:0] cap;
      logic [DATA_WIDTH-1:0] noise;
      script = '{
         ask(16'd1, KNOWN, 1'b0, 2'd0, 16'd0),
         ask(16'hFFFF, KNOWN, 1'b0, 2'd0, 16'd0),
         ask(16'd0, KNOWN, 1'b0, 2'd0, 16'd0),
         poke(CSR_BLOCK_SIZE_0, 16'd100),
         poke(CSR_BLOCK_SIZE_0 + 3'd1, 16'hFFFF),
         poke(CSR_BLOCK_SIZE_3, 16'd50),
         poke(CSR_UNMAPPED, 16'hFFFF),
         ask(16'd0, KNOWN, 1'b0, 2'd0, 16'd0),
         ask(16'd30, KNOWN, 1'b1, 2'd0, 16'd0),
         ask(16'd80, KNOWN, 1'b1, 2'd1, 16'd0),
         ask(16'hFFFF, KNOWN, 1'b0, 2'd0, 16'd0),
         ask(16'd70, KNOWN, 1'b1, 2'd0, 16'd30),
         poke(CSR_FIT_MODE, {14'h3FFF, FIT_BEST}),
         ask(16'd40, KNOWN, 1'b1, 2'd3, 16'd0),
         ask(16'd5, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_FIT_MODE, {14'h0, FIT_WORST}),
         ask(16'd5, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_FIT_MODE, {14'h0, FIT_NEXT}),
         ask(16'd3, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_BLOCK_SIZE_0 + 3'd1, 16'd86),
         poke(CSR_BLOCK_SIZE_0 + 3'd2, 16'd20),
         ask(16'd4, PREDICT, 1'b0, 2'd0, 16'd0),
         ask(16'd15, PREDICT, 1'b0, 2'd0, 16'd0),
         ask(16'd8, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_BLOCK_SIZE_0, 16'd200),
         ask(16'd50, PREDICT, 1'b0, 2'd0, 16'd0),
         ask(16'd5, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_BLOCK_SIZE_3, 16'd0),
         ask(16'd6, PREDICT, 1'b0, 2'd0, 16'd0),
         poke(CSR_FIT_MODE, {14'h0, FIT_FIRST}),
         ask(16'd1, PREDICT, 1'b0, 2'd0, 16'd0),
         ask(16'h8000, PREDICT, 1'b0, 2'd0, 16'd0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct   = 30;
      stall_pct = 15;
      for (n = 0; n < $size(script); n++) begin
         if (script[n].kind == STEP_WRITE) begin
            wait_drained();
            write_csr(script[n].index, script[n].value);
         end else begin
            send_request(script[n].value, script[n].known, script[n].want);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         // hold off until the allocator is idle before reprogramming it
         wait_drained();
         noise      = 16'($urandom);
         noise[1:0] = 2'(p);
         write_csr(CSR_FIT_MODE, noise);
         for (k = 0; k < BLOCKS; k++) begin
            if (p % 3 == 0 || $urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 5))
                  0: cap = '0;
                  1: cap = 16'hFFFF;
                  2: cap = 16'($urandom_range(1, 300));
                  default: cap = 16'($urandom);
               endcase
               write_csr(CSR_BLOCK_SIZE_0 + 3'(k), cap);
            end
         end
         case (p % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 20;
               stall_pct = 10;
            end
            2: begin
               gap_pct   = 60;
               stall_pct = 30;
            end
            default: begin
               gap_pct   = 10;
               stall_pct = 40;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 3))
                     0: size = '0;
                     1: size = 16'd1;
                     2: size = 16'hFFFF;
                     default: size = 16'h8000;
                  endcase
               end
               1, 2, 3, 4: size = 16'($urandom_range(1, 64));
               5, 6, 7: size = 16'($urandom_range(1, 4095));
               default: size = 16'($urandom);
            endcase
            send_request(size, PREDICT, '0);
         end
      end

      wait_drained();
      if (csr_valid) csr_valid <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
